### rtl/scvf_pkg.sv
// Shared constants, codes and command/status types for the sphere cell
// volume fraction block. No dependencies; every other file imports this one.

package scvf_pkg;

   // Sub-cells per axis and derived scaling
   localparam int SUBDIV     = 8;
   localparam int SCALE      = 2 * SUBDIV;
   localparam int SCALE_BITS = $clog2(SCALE);

   // Field widths
   localparam int COORD_W     = 32;
   localparam int SIZE_W      = 31;
   localparam int REG_W       = 31;
   localparam int CSR_INDEX_W = 1;
   localparam int COUNT_W     = 10;

   // Sample counting
   localparam int FULL      = SUBDIV * SUBDIV * SUBDIV;
   localparam int CNT_W     = $clog2(FULL + 1);
   localparam int CNT_EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int IDX_W     = (SUBDIV > 1) ? $clog2(SUBDIV) : 1;

   // Datapath widths
   localparam int DIFF_W = COORD_W + 1;                 // coordinate difference
   localparam int V_W    = COORD_W + SCALE_BITS + 2;    // scaled sample offset, signed
   localparam int MAG_W  = V_W - 1;                     // squaring unit operand
   localparam int SQ_W   = 2 * MAG_W;                   // squaring unit product
   localparam int SUM_W  = SQ_W + 2;                    // sum of three squares
   localparam int D2_W   = 2 * COORD_W + 2;             // center distance squared
   localparam int THR_W  = 2 * (REG_W + 1);             // (r - e)^2, (r + e)^2
   localparam int RS_W   = REG_W + SCALE_BITS;          // scaled radius
   localparam int RR_W   = 2 * RS_W;                    // scaled radius squared

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SEED_RADIUS = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_BAND_WIDTH  = CSR_INDEX_W'(1);

   typedef enum logic [2:0] {
      JOB_D2,
      JOB_INNER,
      JOB_OUTER,
      JOB_RR,
      JOB_SAMPLE
   } scvf_job_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } scvf_axis_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_FULL,
      RES_BAND
   } scvf_res_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] cell_center_x;
      logic signed [COORD_W-1:0] cell_center_y;
      logic signed [COORD_W-1:0] cell_center_z;
      logic signed [COORD_W-1:0] cell_low_x;
      logic signed [COORD_W-1:0] cell_low_y;
      logic signed [COORD_W-1:0] cell_low_z;
      logic [SIZE_W-1:0]         cell_size_x;
      logic [SIZE_W-1:0]         cell_size_y;
      logic [SIZE_W-1:0]         cell_size_z;
      logic signed [COORD_W-1:0] sphere_x;
      logic signed [COORD_W-1:0] sphere_y;
      logic signed [COORD_W-1:0] sphere_z;
   } scvf_item_type;

   typedef struct packed {
      logic [REG_W-1:0] seed_radius;
      logic [REG_W-1:0] band_width;
   } scvf_cfg_type;

   typedef struct packed {
      logic          capture;
      logic          sq_start;
      logic          load_base;
      logic          samp_en;
      logic          load_result;
      scvf_job_type  job;
      scvf_axis_type axis;
      logic [IDX_W-1:0] entry;
      logic [IDX_W-1:0] samp_i;
      logic [IDX_W-1:0] samp_j;
      logic [IDX_W-1:0] samp_k;
      scvf_res_type  res_sel;
   } scvf_cmd_type;

   typedef struct packed {
      logic sq_done;
      logic inner_hit;
      logic outer_in;
   } scvf_status_type;

endpackage

### rtl/scvf_if.sv
// Request and response channel interfaces (valid/ready with payload).
// Depends on scvf_pkg for field widths.

interface scvf_req_if;
   import scvf_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] cell_center_x;
   logic signed [COORD_W-1:0] cell_center_y;
   logic signed [COORD_W-1:0] cell_center_z;
   logic signed [COORD_W-1:0] cell_low_x;
   logic signed [COORD_W-1:0] cell_low_y;
   logic signed [COORD_W-1:0] cell_low_z;
   logic [SIZE_W-1:0]         cell_size_x;
   logic [SIZE_W-1:0]         cell_size_y;
   logic [SIZE_W-1:0]         cell_size_z;
   logic signed [COORD_W-1:0] sphere_x;
   logic signed [COORD_W-1:0] sphere_y;
   logic signed [COORD_W-1:0] sphere_z;

   modport source (
      output valid, cell_center_x, cell_center_y, cell_center_z,
             cell_low_x, cell_low_y, cell_low_z,
             cell_size_x, cell_size_y, cell_size_z,
             sphere_x, sphere_y, sphere_z,
      input  ready
   );

   modport sink (
      input  valid, cell_center_x, cell_center_y, cell_center_z,
             cell_low_x, cell_low_y, cell_low_z,
             cell_size_x, cell_size_y, cell_size_z,
             sphere_x, sphere_y, sphere_z,
      output ready
   );
endinterface

interface scvf_rsp_if;
   import scvf_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] outside_count;
   logic               was_sampled;

   modport source (
      output valid, outside_count, was_sampled,
      input  ready
   );

   modport sink (
      input  valid, outside_count, was_sampled,
      output ready
   );
endinterface

### rtl/scvf_square.sv
// Multi-cycle squaring unit: one half-width multiplier, three partial
// products accumulated in sequence. Depends on scvf_pkg.

module scvf_square import scvf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MAG_W-1:0] operand,
   output logic             done,
   output logic [SQ_W-1:0]  product
);

   localparam int HALF_W = (MAG_W + 1) / 2;
   localparam int ACC_W  = 4 * HALF_W;

   typedef enum logic [1:0] {
      STEP_LO,
      STEP_MID,
      STEP_HI
   } step_type;

   step_type              step_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [2*HALF_W-1:0]   op_ff;
   logic [ACC_W-1:0]      acc_ff;

   logic [HALF_W-1:0]     mul_a;
   logic [HALF_W-1:0]     mul_b;
   logic [2*HALF_W-1:0]   partial;
   logic [ACC_W-1:0]      partial_ext;
   logic [ACC_W-1:0]      addend;

   // Partial product select: lo*lo, 2*lo*hi, hi*hi
   always_comb begin
      case (step_ff)
         STEP_LO: begin
            mul_a = op_ff[HALF_W-1:0];
            mul_b = op_ff[HALF_W-1:0];
         end
         STEP_MID: begin
            mul_a = op_ff[HALF_W-1:0];
            mul_b = op_ff[2*HALF_W-1:HALF_W];
         end
         default: begin
            mul_a = op_ff[2*HALF_W-1:HALF_W];
            mul_b = op_ff[2*HALF_W-1:HALF_W];
         end
      endcase
      partial     = mul_a * mul_b;
      partial_ext = ACC_W'(partial);
      case (step_ff)
         STEP_LO:  addend = partial_ext;
         STEP_MID: addend = partial_ext << (HALF_W + 1);
         default:  addend = partial_ext << (2 * HALF_W);
      endcase
   end

   // Step sequencer and accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_LO;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         // done pulses once, right after the last partial product is added
         done_ff <= !start && busy_ff && (step_ff == STEP_HI);
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_LO;
            op_ff   <= (2 * HALF_W)'(operand);
            acc_ff  <= '0;
         end else if (busy_ff) begin
            acc_ff <= acc_ff + addend;
            case (step_ff)
               STEP_LO:  step_ff <= STEP_MID;
               STEP_MID: step_ff <= STEP_HI;
               default: begin
                  step_ff <= STEP_LO;
                  busy_ff <= 1'b0;
               end
            endcase
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff[SQ_W-1:0];

endmodule

### rtl/scvf_datapath.sv
// Datapath: captured cell, squaring unit, thresholds, per-axis square
// tables and the sample sweep pipeline with counter. Depends on scvf_pkg,
// scvf_square.

module scvf_datapath import scvf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  scvf_cmd_type       cmd,
   input  scvf_item_type      item,
   input  scvf_cfg_type       cfg,
   output scvf_status_type    status,
   output logic [COUNT_W-1:0] outside_count,
   output logic               was_sampled
);

   localparam logic signed [V_W-1:0]   SCALE_V  = V_W'(SCALE);
   localparam logic [RS_W-1:0]         SCALE_R  = RS_W'(SCALE);
   localparam logic [CNT_EXT_W-1:0]    FULL_EXT = CNT_EXT_W'(FULL);

   scvf_item_type             item_ff;
   logic [D2_W-1:0]           d2_ff;
   logic [THR_W-1:0]          inner_sq_ff;
   logic [THR_W-1:0]          outer_sq_ff;
   logic [RR_W-1:0]           rr_ff;
   logic signed [V_W-1:0]     v_ff;
   logic [SQ_W-1:0]           tab_x_ff [SUBDIV];
   logic [SQ_W-1:0]           tab_y_ff [SUBDIV];
   logic [SQ_W-1:0]           tab_z_ff [SUBDIV];
   logic [SQ_W:0]             sxy_ff;
   logic [SQ_W-1:0]           sz_ff;
   logic                      s1_valid_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [COUNT_W-1:0]        out_count_ff;
   logic                      out_sampled_ff;

   logic signed [COORD_W-1:0] cen_sel;
   logic signed [COORD_W-1:0] low_sel;
   logic signed [COORD_W-1:0] sph_sel;
   logic [SIZE_W-1:0]         size_sel;
   logic signed [DIFF_W-1:0]  cen_diff;
   logic signed [DIFF_W-1:0]  cen_neg;
   logic [COORD_W-1:0]        cen_mag;
   logic signed [DIFF_W-1:0]  low_diff;
   logic signed [V_W-1:0]     low_ext;
   logic signed [V_W-1:0]     base;
   logic signed [V_W-1:0]     size_ext;
   logic signed [V_W-1:0]     v_neg;
   logic [MAG_W-1:0]          v_mag;
   logic [REG_W:0]            r_minus_e;
   logic [REG_W:0]            r_plus_e;
   logic [RS_W-1:0]           r_scaled;
   logic [MAG_W-1:0]          sq_operand;
   logic                      sq_done;
   logic [SQ_W-1:0]           sq_product;
   logic [SUM_W-1:0]          sample_sum;
   logic [CNT_EXT_W-1:0]      count_ext;

   // Axis select from captured cell
   always_comb begin
      case (cmd.axis)
         AXIS_Y: begin
            cen_sel  = item_ff.cell_center_y;
            low_sel  = item_ff.cell_low_y;
            sph_sel  = item_ff.sphere_y;
            size_sel = item_ff.cell_size_y;
         end
         AXIS_Z: begin
            cen_sel  = item_ff.cell_center_z;
            low_sel  = item_ff.cell_low_z;
            sph_sel  = item_ff.sphere_z;
            size_sel = item_ff.cell_size_z;
         end
         default: begin
            cen_sel  = item_ff.cell_center_x;
            low_sel  = item_ff.cell_low_x;
            sph_sel  = item_ff.sphere_x;
            size_sel = item_ff.cell_size_x;
         end
      endcase
   end

   // Center offset magnitude, always below 2^32
   assign cen_diff = $signed({cen_sel[COORD_W-1], cen_sel})
                   - $signed({sph_sel[COORD_W-1], sph_sel});
   assign cen_neg  = -cen_diff;
   assign cen_mag  = cen_diff[DIFF_W-1] ? cen_neg[COORD_W-1:0] : cen_diff[COORD_W-1:0];

   // Scaled sample coordinate: SCALE*(low - sph) + (2n+1)*size
   assign low_diff = $signed({low_sel[COORD_W-1], low_sel})
                   - $signed({sph_sel[COORD_W-1], sph_sel});
   assign low_ext  = $signed({{(V_W-DIFF_W){low_diff[DIFF_W-1]}}, low_diff});
   assign base     = low_ext * SCALE_V;
   assign size_ext = $signed({{(V_W-SIZE_W){1'b0}}, size_sel});
   assign v_neg    = -v_ff;
   assign v_mag    = v_ff[V_W-1] ? v_neg[MAG_W-1:0] : v_ff[MAG_W-1:0];

   // Radius terms
   assign r_minus_e = {1'b0, cfg.seed_radius} - {1'b0, cfg.band_width};
   assign r_plus_e  = {1'b0, cfg.seed_radius} + {1'b0, cfg.band_width};
   assign r_scaled  = RS_W'(cfg.seed_radius) * SCALE_R;

   // Squaring unit operand
   always_comb begin
      case (cmd.job)
         JOB_D2:    sq_operand = MAG_W'(cen_mag);
         JOB_INNER: sq_operand = MAG_W'(r_minus_e);
         JOB_OUTER: sq_operand = MAG_W'(r_plus_e);
         JOB_RR:    sq_operand = MAG_W'(r_scaled);
         default:   sq_operand = v_mag;
      endcase
   end

   scvf_square u_square (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.sq_start),
      .operand (sq_operand),
      .done    (sq_done),
      .product (sq_product)
   );

   // Cell capture, sample coordinate walk and product stores
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= item;
         d2_ff   <= '0;
      end
      if (cmd.load_base) begin
         v_ff <= base + size_ext;
      end else if (cmd.sq_start && (cmd.job == JOB_SAMPLE)) begin
         v_ff <= v_ff + (size_ext <<< 1);
      end
      if (sq_done) begin
         case (cmd.job)
            JOB_D2:    d2_ff       <= d2_ff + sq_product[D2_W-1:0];
            JOB_INNER: inner_sq_ff <= sq_product[THR_W-1:0];
            JOB_OUTER: outer_sq_ff <= sq_product[THR_W-1:0];
            JOB_RR:    rr_ff       <= sq_product[RR_W-1:0];
            JOB_SAMPLE: begin
               case (cmd.axis)
                  AXIS_Y:  tab_y_ff[cmd.entry] <= sq_product;
                  AXIS_Z:  tab_z_ff[cmd.entry] <= sq_product;
                  default: tab_x_ff[cmd.entry] <= sq_product;
               endcase
            end
            default: ;
         endcase
      end
   end

   // Band decision flags
   assign status.sq_done   = sq_done;
   assign status.inner_hit = (cfg.seed_radius > cfg.band_width)
                           && (d2_ff < D2_W'(inner_sq_ff));
   assign status.outer_in  = d2_ff < D2_W'(outer_sq_ff);

   // Sweep pipeline: x+y sum, then +z and compare against scaled radius
   assign sample_sum = SUM_W'(sxy_ff) + SUM_W'(sz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.samp_en;
      end
      if (cmd.samp_en) begin
         sxy_ff <= (SQ_W + 1)'(tab_x_ff[cmd.samp_i]) + (SQ_W + 1)'(tab_y_ff[cmd.samp_j]);
         sz_ff  <= tab_z_ff[cmd.samp_k];
      end
      if (cmd.capture) begin
         count_ff <= '0;
      end else if (s1_valid_ff && (sample_sum > SUM_W'(rr_ff))) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // Result register
   assign count_ext = CNT_EXT_W'(count_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         case (cmd.res_sel)
            RES_FULL: begin
               out_count_ff   <= FULL_EXT[COUNT_W-1:0];
               out_sampled_ff <= 1'b0;
            end
            RES_BAND: begin
               out_count_ff   <= count_ext[COUNT_W-1:0];
               out_sampled_ff <= 1'b1;
            end
            default: begin
               out_count_ff   <= '0;
               out_sampled_ff <= 1'b0;
            end
         endcase
      end
   end

   assign outside_count = out_count_ff;
   assign was_sampled   = out_sampled_ff;

endmodule

### rtl/scvf_ctrl.sv
// Controller: sequences the squaring jobs, the band decision, the table
// fill and the sample sweep, and owns the handshakes. Depends on scvf_pkg.

module scvf_ctrl import scvf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  scvf_status_type status,
   output scvf_cmd_type    cmd
);

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SUBDIV - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ISSUE,
      S_WAIT,
      S_DECIDE,
      S_LOAD,
      S_SWEEP,
      S_DRAIN,
      S_FINISH
   } state_type;

   state_type     state_ff;
   scvf_job_type  job_ff;
   scvf_axis_type axis_ff;
   logic [IDX_W-1:0] entry_ff;
   logic [IDX_W-1:0] samp_i_ff;
   logic [IDX_W-1:0] samp_j_ff;
   logic [IDX_W-1:0] samp_k_ff;
   scvf_res_type  res_ff;
   logic          rsp_valid_ff;

   scvf_axis_type next_axis;
   logic          out_free;

   always_comb begin
      case (axis_ff)
         AXIS_X:  next_axis = AXIS_Y;
         AXIS_Y:  next_axis = AXIS_Z;
         default: next_axis = AXIS_X;
      endcase
   end

   // Output register may be reloaded once its transaction completes
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Commands to the datapath
   always_comb begin
      cmd.capture     = (state_ff == S_IDLE) && req_valid;
      cmd.sq_start    = (state_ff == S_ISSUE);
      cmd.load_base   = (state_ff == S_LOAD);
      cmd.samp_en     = (state_ff == S_SWEEP);
      cmd.load_result = (state_ff == S_FINISH) && out_free;
      cmd.job         = job_ff;
      cmd.axis        = axis_ff;
      cmd.entry       = entry_ff;
      cmd.samp_i      = samp_i_ff;
      cmd.samp_j      = samp_j_ff;
      cmd.samp_k      = samp_k_ff;
      cmd.res_sel     = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         job_ff       <= JOB_D2;
         axis_ff      <= AXIS_X;
         entry_ff     <= '0;
         samp_i_ff    <= '0;
         samp_j_ff    <= '0;
         samp_k_ff    <= '0;
         res_ff       <= RES_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Result taken; in S_FINISH the reload below decides valid
         if (rsp_valid_ff && rsp_ready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  job_ff   <= JOB_D2;
                  axis_ff  <= AXIS_X;
                  state_ff <= S_ISSUE;
               end
            end
            S_ISSUE: state_ff <= S_WAIT;
            S_WAIT: begin
               if (status.sq_done) begin
                  case (job_ff)
                     JOB_D2: begin
                        state_ff <= S_ISSUE;
                        if (axis_ff == AXIS_Z) begin
                           job_ff <= JOB_INNER;
                        end else begin
                           axis_ff <= next_axis;
                        end
                     end
                     JOB_INNER: begin
                        job_ff   <= JOB_OUTER;
                        state_ff <= S_ISSUE;
                     end
                     JOB_OUTER: state_ff <= S_DECIDE;
                     JOB_RR: begin
                        axis_ff  <= AXIS_X;
                        entry_ff <= '0;
                        state_ff <= S_LOAD;
                     end
                     JOB_SAMPLE: begin
                        if (entry_ff == IDX_LAST) begin
                           entry_ff <= '0;
                           if (axis_ff == AXIS_Z) begin
                              samp_i_ff <= '0;
                              samp_j_ff <= '0;
                              samp_k_ff <= '0;
                              state_ff  <= S_SWEEP;
                           end else begin
                              axis_ff  <= next_axis;
                              state_ff <= S_LOAD;
                           end
                        end else begin
                           entry_ff <= entry_ff + 1'b1;
                           state_ff <= S_ISSUE;
                        end
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            // Deep inside, well outside, or in the band
            S_DECIDE: begin
               if (status.inner_hit) begin
                  res_ff   <= RES_ZERO;
                  state_ff <= S_FINISH;
               end else if (!status.outer_in) begin
                  res_ff   <= RES_FULL;
                  state_ff <= S_FINISH;
               end else begin
                  res_ff   <= RES_BAND;
                  job_ff   <= JOB_RR;
                  state_ff <= S_ISSUE;
               end
            end
            S_LOAD: begin
               job_ff   <= JOB_SAMPLE;
               state_ff <= S_ISSUE;
            end
            // One sample point per cycle, k fastest
            S_SWEEP: begin
               if (samp_k_ff == IDX_LAST) begin
                  samp_k_ff <= '0;
                  if (samp_j_ff == IDX_LAST) begin
                     samp_j_ff <= '0;
                     if (samp_i_ff == IDX_LAST) begin
                        state_ff <= S_DRAIN;
                     end else begin
                        samp_i_ff <= samp_i_ff + 1'b1;
                     end
                  end else begin
                     samp_j_ff <= samp_j_ff + 1'b1;
                  end
               end else begin
                  samp_k_ff <= samp_k_ff + 1'b1;
               end
            end
            S_DRAIN: state_ff <= S_FINISH;
            S_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### rtl/sphere_cell_volume_fraction.sv
// Top level: configuration registers, channel hookup, controller and
// datapath. Depends on scvf_pkg, scvf_if, scvf_ctrl, scvf_datapath.
//
//   Port group    Direction  Transaction
//   req_bus       in         one cell: center, lower corner, size, sphere center
//   rsp_bus       out        outside_count, was_sampled
//   csr_*         in         register write, index 0 seed_radius, 1 band_width
//
// A cell clearly inside or outside the band is decided once the centre distance
// and both thresholds are squared; a band cell also squares the scaled radius,
// fills three tables of SUBDIV squares and sweeps SUBDIV^3 points. All squares
// share one 19x19 multiplier; the sweep tests one sample point per cycle.
// Reset restores seed_radius 65536 and band_width 6554; no clearing pass.
// The result waits in an output register; req_bus.ready returns as soon as it
// is loaded, and the controller only holds if a second result is due first.

module sphere_cell_volume_fraction import scvf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   scvf_req_if.sink               req_bus,
   scvf_rsp_if.source             rsp_bus,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [REG_W-1:0]       csr_write_data
);

   logic [REG_W-1:0] seed_radius_ff;
   logic [REG_W-1:0] band_width_ff;

   scvf_cfg_type    cfg;
   scvf_item_type   item;
   scvf_cmd_type    cmd;
   scvf_status_type status;
   logic            req_ready;
   logic            rsp_valid;
   logic [COUNT_W-1:0] outside_count;
   logic            was_sampled;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_radius_ff <= REG_W'(65536);
         band_width_ff  <= REG_W'(6554);
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_SEED_RADIUS: seed_radius_ff <= csr_write_data;
            REG_BAND_WIDTH:  band_width_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign cfg.seed_radius = seed_radius_ff;
   assign cfg.band_width  = band_width_ff;

   // Request payload
   assign item.cell_center_x = req_bus.cell_center_x;
   assign item.cell_center_y = req_bus.cell_center_y;
   assign item.cell_center_z = req_bus.cell_center_z;
   assign item.cell_low_x    = req_bus.cell_low_x;
   assign item.cell_low_y    = req_bus.cell_low_y;
   assign item.cell_low_z    = req_bus.cell_low_z;
   assign item.cell_size_x   = req_bus.cell_size_x;
   assign item.cell_size_y   = req_bus.cell_size_y;
   assign item.cell_size_z   = req_bus.cell_size_z;
   assign item.sphere_x      = req_bus.sphere_x;
   assign item.sphere_y      = req_bus.sphere_y;
   assign item.sphere_z      = req_bus.sphere_z;

   scvf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   scvf_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .item          (item),
      .cfg           (cfg),
      .status        (status),
      .outside_count (outside_count),
      .was_sampled   (was_sampled)
   );

   assign req_bus.ready         = req_ready;
   assign rsp_bus.valid         = rsp_valid;
   assign rsp_bus.outside_count = outside_count;
   assign rsp_bus.was_sampled   = was_sampled;

endmodule

### tb/sv/tb_sphere_cell_volume_fraction.sv
// Self-checking testbench for sphere_cell_volume_fraction: band edges, register
// extremes, output backpressure and random cells against a built-in predictor.
// Depends on scvf_pkg, scvf_if (scvf_req_if, scvf_rsp_if) and the block's RTL.

module tb_sphere_cell_volume_fraction;
   timeunit 1ns;
   timeprecision 1ps;
   import scvf_pkg::*;

   localparam longint ONE          = 65536;
   localparam longint MIN_COORD    = -64'sd2147483648;
   localparam longint MAX_COORD    = 64'sd2147483647;
   localparam longint MAX_SIZE     = 64'sd2147483647;
   localparam longint MAX_REG      = 64'sd2147483647;
   localparam longint RESET_RADIUS = 65536;
   localparam longint RESET_BAND   = 6554;
   localparam int     BAND_LATENCY = 37 + 15 * SUBDIV + SUBDIV * SUBDIV * SUBDIV;
   localparam int     LONG_HOLD    = 3000;
   localparam int     CYCLE_LIMIT  = 2000000;
   localparam int     RANDOM_PER_SETTING = 82;

   typedef struct {
      logic [COUNT_W-1:0] outside_count;
      logic               was_sampled;
   } fraction_type;

   logic clock;
   logic reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [REG_W-1:0]       csr_write_data;

   scvf_req_if cell_bus ();
   scvf_rsp_if fraction_bus ();

   sphere_cell_volume_fraction DUT (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (cell_bus),
      .rsp_bus          (fraction_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Register mirror and bookkeeping
   logic [REG_W-1:0] cfg_radius = RESET_RADIUS[REG_W-1:0];
   logic [REG_W-1:0] cfg_band   = RESET_BAND[REG_W-1:0];
   fraction_type expected_fractions [$];
   int  fail_count       = 0;
   int  results_checked  = 0;
   int  sampled_count    = 0;
   int  settings_count   = 0;
   int  cycle_count      = 0;
   int  rsp_hold_request = 0;
   bit  req_burst        = 1'b0;
   bit  rsp_burst        = 1'b0;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Exact squared magnitude, wide enough for scaled sample offsets
   function automatic logic [127:0] square_mag(longint v);
      logic [127:0] m;
      m = (v < 0) ? -v : v;
      return m * m;
   endfunction

   // Expected outside count for one cell under the current register values
   function automatic fraction_type predict_fraction(scvf_item_type c);
      longint cen[3], low[3], siz[3], sph[3], base[3];
      logic [127:0] d2, rr, sx, sxy;
      longint r, e, scale;
      int count;
      fraction_type res;
      cen[0] = $signed(c.cell_center_x);
      cen[1] = $signed(c.cell_center_y);
      cen[2] = $signed(c.cell_center_z);
      low[0] = $signed(c.cell_low_x);
      low[1] = $signed(c.cell_low_y);
      low[2] = $signed(c.cell_low_z);
      siz[0] = c.cell_size_x;
      siz[1] = c.cell_size_y;
      siz[2] = c.cell_size_z;
      sph[0] = $signed(c.sphere_x);
      sph[1] = $signed(c.sphere_y);
      sph[2] = $signed(c.sphere_z);
      r = cfg_radius;
      e = cfg_band;
      d2 = square_mag(cen[0] - sph[0]) + square_mag(cen[1] - sph[1])
         + square_mag(cen[2] - sph[2]);
      res.was_sampled = 1'b0;
      // inside test only makes sense when radius exceeds the band
      if (r > e && d2 < square_mag(r - e)) begin
         count = 0;
      end else if (d2 < square_mag(r + e)) begin
         // sub-cell centers scaled by 2*SUBDIV so they stay integral
         scale = 2 * SUBDIV;
         rr = square_mag(scale * r);
         for (int a = 0; a < 3; a++) base[a] = scale * (low[a] - sph[a]);
         count = 0;
         res.was_sampled = 1'b1;
         for (int i = 0; i < SUBDIV; i++) begin
            sx = square_mag(base[0] + (2 * i + 1) * siz[0]);
            for (int j = 0; j < SUBDIV; j++) begin
               sxy = sx + square_mag(base[1] + (2 * j + 1) * siz[1]);
               for (int k = 0; k < SUBDIV; k++)
                  if (sxy + square_mag(base[2] + (2 * k + 1) * siz[2]) > rr) count++;
            end
         end
      end else begin
         count = SUBDIV * SUBDIV * SUBDIV;
      end
      res.outside_count = count[COUNT_W-1:0];
      return res;
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
      if (v > MAX_COORD) v = MAX_COORD;
      if (v < MIN_COORD) v = MIN_COORD;
      return v[COORD_W-1:0];
   endfunction

   function automatic logic [SIZE_W-1:0] clamp_size(longint v);
      if (v > MAX_SIZE) v = MAX_SIZE;
      if (v < 0) v = 0;
      return v[SIZE_W-1:0];
   endfunction

   // Uniform value in [-lim, lim]
   function automatic longint rand_span(longint lim);
      longint unsigned u;
      if (lim <= 0) return 0;
      u = {$urandom, $urandom};
      return longint'(u % longint'(2 * lim + 1)) - lim;
   endfunction

   function automatic scvf_item_type cell_of(longint cx, cy, cz, lx, ly, lz,
                                             sx, sy, sz, px, py, pz);
      scvf_item_type c;
      c.cell_center_x = clamp_coord(cx);
      c.cell_center_y = clamp_coord(cy);
      c.cell_center_z = clamp_coord(cz);
      c.cell_low_x    = clamp_coord(lx);
      c.cell_low_y    = clamp_coord(ly);
      c.cell_low_z    = clamp_coord(lz);
      c.cell_size_x   = clamp_size(sx);
      c.cell_size_y   = clamp_size(sy);
      c.cell_size_z   = clamp_size(sz);
      c.sphere_x      = clamp_coord(px);
      c.sphere_y      = clamp_coord(py);
      c.sphere_z      = clamp_coord(pz);
      return c;
   endfunction

   // Random sphere, center at the given offset from it, random cell extent
   function automatic scvf_item_type place_cell(input longint off[3]);
      longint sph[3], cen[3], low[3], siz[3];
      real span;
      span = 2.0 * real'(cfg_radius) + 2.0;
      for (int a = 0; a < 3; a++) begin
         sph[a] = longint'($signed($urandom)) >>> $urandom_range(1, 12);
         cen[a] = sph[a] + off[a];
         case ($urandom_range(0, 3))
            0:       siz[a] = $urandom_range(0, 255);
            1:       siz[a] = $urandom >> 1;
            default: siz[a] = longint'(span * ($urandom / 4294967296.0));
         endcase
         low[a] = cen[a] - siz[a] / 2;
         if ($urandom_range(0, 7) == 0) low[a] += rand_span(siz[a] + 1);
      end
      return cell_of(cen[0], cen[1], cen[2], low[0], low[1], low[2],
                     siz[0], siz[1], siz[2], sph[0], sph[1], sph[2]);
   endfunction

   // Cell center at a random direction and a distance within [lo, hi]
   function automatic scvf_item_type near_sphere_cell(real lo, real hi);
      longint off[3];
      int dir[3];
      real t, norm;
      t = lo + (hi - lo) * ($urandom / 4294967296.0);
      do begin
         for (int a = 0; a < 3; a++) dir[a] = $urandom_range(0, 2000) - 1000;
      end while (dir[0] == 0 && dir[1] == 0 && dir[2] == 0);
      norm = $sqrt(real'(dir[0] * dir[0] + dir[1] * dir[1] + dir[2] * dir[2]));
      for (int a = 0; a < 3; a++) off[a] = longint'(t * dir[a] / norm);
      return place_cell(off);
   endfunction

   function automatic scvf_item_type next_random_cell();
      longint r, e, band_off;
      longint off[3];
      real inner, outer;
      int pick;
      scvf_item_type c;
      r = cfg_radius;
      e = cfg_band;
      inner = (r > e) ? real'(r - e) : 0.0;
      outer = real'(r + e);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         c = near_sphere_cell(inner, outer);
      end else if (pick < 70) begin
         // axis-aligned center exactly on or next to a band edge
         case ($urandom_range(0, 3))
            0:       band_off = (r > e) ? r - e : 0;
            1:       band_off = (r > e) ? r - e - 1 : 0;
            2:       band_off = r + e;
            default: band_off = r + e - 1;
         endcase
         off = '{0, 0, 0};
         off[$urandom_range(0, 2)] = $urandom_range(0, 1) ? band_off : -band_off;
         c = place_cell(off);
      end else if (pick < 85) begin
         if ($urandom_range(0, 1)) c = near_sphere_cell(0.0, inner);
         else c = near_sphere_cell(outer, 2.0 * outer + 1.0);
      end else begin
         // unconstrained bit patterns
         c.cell_center_x = $urandom;
         c.cell_center_y = $urandom;
         c.cell_center_z = $urandom;
         c.cell_low_x    = $urandom;
         c.cell_low_y    = $urandom;
         c.cell_low_z    = $urandom;
         c.cell_size_x   = SIZE_W'($urandom);
         c.cell_size_y   = SIZE_W'($urandom);
         c.cell_size_z   = SIZE_W'($urandom);
         c.sphere_x      = $urandom;
         c.sphere_y      = $urandom;
         c.sphere_z      = $urandom;
      end
      return c;
   endfunction

   // Offer one cell, after a random gap unless in burst mode, and hold it until accepted
   task automatic offer_cell(input scvf_item_type c);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 15);
      @(negedge clock);
      if (gap > 0) begin
         cell_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      cell_bus.cell_center_x = c.cell_center_x;
      cell_bus.cell_center_y = c.cell_center_y;
      cell_bus.cell_center_z = c.cell_center_z;
      cell_bus.cell_low_x    = c.cell_low_x;
      cell_bus.cell_low_y    = c.cell_low_y;
      cell_bus.cell_low_z    = c.cell_low_z;
      cell_bus.cell_size_x   = c.cell_size_x;
      cell_bus.cell_size_y   = c.cell_size_y;
      cell_bus.cell_size_z   = c.cell_size_z;
      cell_bus.sphere_x      = c.sphere_x;
      cell_bus.sphere_y      = c.sphere_y;
      cell_bus.sphere_z      = c.sphere_z;
      cell_bus.valid         = 1'b1;
      do @(posedge clock); while (!cell_bus.ready);
   endtask

   // Stop offering and wait until every outstanding result is back
   task automatic wait_drained();
      @(negedge clock);
      cell_bus.valid = 1'b0;
      while (expected_fractions.size() > 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [REG_W-1:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = data;
      case (index)
         REG_SEED_RADIUS: cfg_radius = data;
         REG_BAND_WIDTH:  cfg_band   = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic set_config(input longint radius, input longint band);
      wait_drained();
      write_reg(REG_SEED_RADIUS, radius[REG_W-1:0]);
      write_reg(REG_BAND_WIDTH, band[REG_W-1:0]);
      settings_count++;
   endtask

   // Receiver: per-result random stall, or a long hold on request
   initial begin
      int stall;
      stall = 0;
      fraction_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (fraction_bus.valid && fraction_bus.ready)
            stall = rsp_burst ? 0 : $urandom_range(0, 15);
         @(negedge clock);
         if (rsp_hold_request > 0) begin
            stall = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (stall > 0) begin
            stall--;
            fraction_bus.ready = 1'b0;
         end else begin
            fraction_bus.ready = 1'b1;
         end
      end
   end

   // Monitor: check each returned result, then queue the prediction for a new cell
   always @(posedge clock) begin
      scvf_item_type seen;
      fraction_type exp_res;
      if (!reset && fraction_bus.valid && fraction_bus.ready) begin
         if (expected_fractions.size() == 0) begin
            $error("result with nothing outstanding: outside_count %0d, was_sampled %0b",
                   fraction_bus.outside_count, fraction_bus.was_sampled);
            fail_count++;
         end else begin
            exp_res = expected_fractions.pop_front();
            results_checked++;
            if (exp_res.was_sampled) sampled_count++;
            if (fraction_bus.outside_count !== exp_res.outside_count) begin
               $error("outside_count mismatch: expected %0d, actual %0d",
                      exp_res.outside_count, fraction_bus.outside_count);
               fail_count++;
            end
            if (fraction_bus.was_sampled !== exp_res.was_sampled) begin
               $error("was_sampled mismatch: expected %0b, actual %0b",
                      exp_res.was_sampled, fraction_bus.was_sampled);
               fail_count++;
            end
         end
      end
      if (!reset && cell_bus.valid && cell_bus.ready) begin
         seen.cell_center_x = cell_bus.cell_center_x;
         seen.cell_center_y = cell_bus.cell_center_y;
         seen.cell_center_z = cell_bus.cell_center_z;
         seen.cell_low_x    = cell_bus.cell_low_x;
         seen.cell_low_y    = cell_bus.cell_low_y;
         seen.cell_low_z    = cell_bus.cell_low_z;
         seen.cell_size_x   = cell_bus.cell_size_x;
         seen.cell_size_y   = cell_bus.cell_size_y;
         seen.cell_size_z   = cell_bus.cell_size_z;
         seen.sphere_x      = cell_bus.sphere_x;
         seen.sphere_y      = cell_bus.sphere_y;
         seen.sphere_z      = cell_bus.sphere_z;
         expected_fractions.push_back(predict_fraction(seen));
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("run timed out after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
   end

   // Band edges and field extremes at the reset register values
   task automatic test_band_edges();
      longint in_edge, out_edge, px, py, pz;
      in_edge  = RESET_RADIUS - RESET_BAND;
      out_edge = RESET_RADIUS + RESET_BAND;
      // deep inside, exactly on the inner edge, just inside it
      offer_cell(cell_of(0, 0, 0, -32768, -32768, -32768, ONE, ONE, ONE, 0, 0, 0));
      offer_cell(cell_of(in_edge, 0, 0, in_edge - 32768, -32768, -32768,
                         ONE, ONE, ONE, 0, 0, 0));
      offer_cell(cell_of(in_edge - 1, 0, 0, in_edge - 32768, -32768, -32768,
                         ONE, ONE, ONE, 0, 0, 0));
      // exactly on the outer edge, just inside it
      offer_cell(cell_of(out_edge, 0, 0, out_edge - 32768, -32768, -32768,
                         ONE, ONE, ONE, 0, 0, 0));
      offer_cell(cell_of(out_edge - 1, 0, 0, out_edge - 32768, -32768, -32768,
                         ONE, ONE, ONE, 0, 0, 0));
      // one sub-cell center lands exactly on the surface
      offer_cell(cell_of(ONE, 0, 0, ONE - 4096, -4096, -4096, ONE, ONE, ONE, 0, 0, 0));
      // zero-size cell: every sample on the surface, then every sample just outside
      offer_cell(cell_of(ONE, 0, 0, ONE, 0, 0, 0, 0, 0, 0, 0, 0));
      offer_cell(cell_of(ONE, 0, 0, ONE + 1, 0, 0, 0, 0, 0, 0, 0, 0));
      // coordinate and size extremes
      offer_cell(cell_of(MAX_COORD, MAX_COORD, MAX_COORD, MIN_COORD, MIN_COORD, MIN_COORD,
                         MAX_SIZE, MAX_SIZE, MAX_SIZE, MIN_COORD, MIN_COORD, MIN_COORD));
      offer_cell(cell_of(ONE, 0, 0, MIN_COORD, MIN_COORD, MIN_COORD,
                         MAX_SIZE, MAX_SIZE, MAX_SIZE, 0, 0, 0));
      offer_cell(cell_of(0, ONE, 0, MAX_COORD, MAX_COORD, MAX_COORD,
                         MAX_SIZE, MAX_SIZE, MAX_SIZE, 0, 0, 0));
      // off-origin sphere, diagonal offset inside the band
      px = MIN_COORD + 200000;
      py = MAX_COORD - 200000;
      pz = 12345;
      offer_cell(cell_of(px + 40000, py - 40000, pz + 20000,
                         px + 40000 - 32768, py - 40000 - 32768, pz + 20000 - 32768,
                         ONE, ONE, ONE, px, py, pz));
      offer_cell(cell_of(MIN_COORD, MAX_COORD, MIN_COORD, MIN_COORD, MAX_COORD, MIN_COORD,
                         ONE, ONE, ONE, MIN_COORD, MAX_COORD, MIN_COORD));
   endtask

   // Radius equal to, below and far above the band; zero and full-scale registers
   task automatic test_register_extremes();
      set_config(ONE, ONE);
      offer_cell(cell_of(0, 0, 0, -32768, -32768, -32768, ONE, ONE, ONE, 0, 0, 0));
      offer_cell(cell_of(2 * ONE, 0, 0, 0, 0, 0, ONE, ONE, ONE, 0, 0, 0));
      set_config(1000, 5000);
      offer_cell(cell_of(0, 0, 0, -4000, -4000, -4000, 8000, 8000, 8000, 0, 0, 0));
      offer_cell(cell_of(6000, 0, 0, 0, 0, 0, 8000, 8000, 8000, 0, 0, 0));
      set_config(0, 0);
      offer_cell(cell_of(0, 0, 0, -32768, -32768, -32768, ONE, ONE, ONE, 0, 0, 0));
      set_config(0, ONE);
      offer_cell(cell_of(0, 0, 0, -4096, -4096, -4096, ONE, ONE, ONE, 0, 0, 0));
      set_config(MAX_REG, MAX_REG);
      offer_cell(cell_of(0, 0, 0, MIN_COORD, MIN_COORD, MIN_COORD,
                         MAX_SIZE, MAX_SIZE, MAX_SIZE, 0, 0, 0));
      offer_cell(cell_of(MIN_COORD, MIN_COORD, MIN_COORD, 0, 0, 0, ONE, ONE, ONE,
                         MAX_COORD, MAX_COORD, MAX_COORD));
      set_config(MAX_REG, 0);
      offer_cell(cell_of(5, 5, 5, 0, 0, 0, ONE, ONE, ONE, 5, 5, 5));
      offer_cell(cell_of(MAX_COORD, 0, 0, MIN_COORD, 0, 0, MAX_SIZE, ONE, ONE,
                         MIN_COORD, 0, 0));
      set_config(RESET_RADIUS, RESET_BAND);
   endtask

   // Result side held off for a long stretch while cells keep coming
   task automatic test_output_backpressure();
      real inner, outer;
      inner = real'(cfg_radius) - real'(cfg_band);
      outer = real'(cfg_radius) + real'(cfg_band);
      wait_drained();
      req_burst = 1'b1;
      rsp_hold_request = LONG_HOLD;
      for (int n = 0; n < 10; n++) begin
         if (n % 4 == 0) offer_cell(near_sphere_cell(inner, outer));
         else offer_cell(near_sphere_cell(outer, 2.0 * outer));
      end
      wait_drained();
      req_burst = 1'b0;
   endtask

   // Mostly cells near the sphere surface, over several register settings
   task automatic test_random_cells();
      longint radius, band;
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin radius = RESET_RADIUS; band = RESET_BAND; end
            1: begin radius = 5 * ONE; band = 2 * ONE; end
            2: begin radius = ONE / 2; band = ONE; end
            3: begin
               radius = $urandom_range(0, 1 << 24);
               band   = $urandom_range(0, radius);
            end
            4: begin radius = MAX_REG; band = $urandom_range(0, 1 << 30); end
            default: begin radius = $urandom >> 1; band = $urandom >> 1; end
         endcase
         set_config(radius, band);
         for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
            if (n % 20 == 0) begin
               req_burst = ($urandom_range(0, 3) == 0);
               rsp_burst = ($urandom_range(0, 3) == 0);
            end
            offer_cell(next_random_cell());
         end
      end
      req_burst = 1'b0;
      rsp_burst = 1'b0;
   endtask

   // Sequence
   initial begin
      reset                  = 1'b1;
      csr_write_enable       = 1'b0;
      csr_index              = REG_SEED_RADIUS;
      csr_write_data         = '0;
      cell_bus.valid         = 1'b0;
      cell_bus.cell_center_x = '0;
      cell_bus.cell_center_y = '0;
      cell_bus.cell_center_z = '0;
      cell_bus.cell_low_x    = '0;
      cell_bus.cell_low_y    = '0;
      cell_bus.cell_low_z    = '0;
      cell_bus.cell_size_x   = '0;
      cell_bus.cell_size_y   = '0;
      cell_bus.cell_size_z   = '0;
      cell_bus.sphere_x      = '0;
      cell_bus.sphere_y      = '0;
      cell_bus.sphere_z      = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_band_edges();
      test_register_extremes();
      test_output_backpressure();
      test_random_cells();

      wait_drained();
      repeat (BAND_LATENCY) @(posedge clock);
      $display("Covered %0d cells (%0d supersampled) over %0d register settings,",
               results_checked, sampled_count, settings_count);
      $display("with random idling, burst stretches and a %0d-cycle result hold-off.",
               LONG_HOLD);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
